FILE: rtl/hv_divider_pid_duty_macros.svh
// Assertion macros for the voltage loop, used by hvd_core.
// Each macro samples on clk and is disabled while rst_n is low, so the
// module that uses it must have ports of those names.
`ifndef HV_DIVIDER_PID_DUTY_MACROS_SVH
`define HV_DIVIDER_PID_DUTY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hvd_pkg.sv
// Package for the high-voltage divider PID loop: widths, constants,
// register codes, sequencer states and the structs passed between modules.
// No dependencies.
package hvd_pkg;

    localparam int DUTY_BITS     = 10;
    localparam int INTEGRAL_BITS = 40;

    localparam int MV_W       = 12;
    localparam int TARGET_W   = 17;
    localparam int GAIN_W     = 24;
    localparam int RAIL_W     = 18;
    localparam int ERR_W      = 19;
    localparam int DERR_W     = 20;
    localparam int ERR50_W    = 25;
    localparam int DERR2500_W = 32;
    localparam int N_W        = 29;
    localparam int QRAIL_W    = 18;
    localparam int ISUM_W     = INTEGRAL_BITS + 1;
    localparam int ILO_W      = 24;
    localparam int ACC_W      = INTEGRAL_BITS + 34;
    localparam int H_W        = ACC_W - ILO_W;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Divider scaling: rail = floor((mv * 80544 + 1062) / 2125) - 10240,
    // capped at RAIL_MAX. The division is a multiplication by
    // ceil(2^41 / 2125), which is exact for every 12-bit reading.
    localparam int unsigned SCALE_MUL  = 80544;
    localparam int unsigned RAIL_ROUND = 1062;
    localparam int          RAIL_SHIFT = 41;
    localparam int unsigned RAIL_RECIP = 1034834474;
    localparam int          OFFSET_Q8  = 10240;
    localparam int          RAIL_MAX   = 131071;

    localparam int STEP_RATE  = 50;
    localparam int DUTY_FULL  = (1 << DUTY_BITS) - 1;
    localparam int DUTY_LIMIT = DUTY_FULL * 4 / 5;
    // Any value at or above this bound divides to more than the limit.
    localparam int H_LIMIT    = STEP_RATE * (DUTY_LIMIT + 1);
    localparam int HQ_W       = $clog2(H_LIMIT);
    // Reciprocal of the step rate, exact for every value below H_LIMIT.
    localparam int QUO_SHIFT  = DUTY_BITS + 12;
    localparam int QUO_RECIP  = ((1 << QUO_SHIFT) + STEP_RATE - 1) / STEP_RATE;

    localparam int TARGET_RESET = 0;
    localparam int PROP_RESET   = 6554;
    localparam int INTEG_RESET  = 655;
    localparam int DERIV_RESET  = 655;

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PROP   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INTEG  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DERIV  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFS,
        ST_DIVR,
        ST_RAIL,
        ST_ERR,
        ST_UPD,
        ST_MP,
        ST_MD,
        ST_MIL,
        ST_MIH,
        ST_SUMH,
        ST_CLAMP,
        ST_QUO
    } hvd_state_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target_voltage;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
    } hvd_cfg_t;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } hvd_mul_req_t;

endpackage

FILE: rtl/hvd_if.sv
// Valid/ready channel interfaces for the reading input and the duty result.
// Depends on hvd_pkg for the payload widths.
interface hvd_sample_if;
    import hvd_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] sense_millivolts;

    modport source (output valid, output sense_millivolts, input ready);
    modport sink   (input valid, input sense_millivolts, output ready);
endinterface

interface hvd_result_if;
    import hvd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DUTY_BITS-1:0]     pwm_duty;
    logic signed [RAIL_W-1:0] rail_voltage;

    modport source (output valid, output pwm_duty, output rail_voltage, input ready);
    modport sink   (input valid, input pwm_duty, input rail_voltage, output ready);
endinterface

FILE: rtl/hvd_regs.sv
// APB-style configuration registers: setpoint and the three loop gains.
// Depends on hvd_pkg for the register codes, reset values and hvd_cfg_t.
module hvd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hvd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hvd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hvd_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output hvd_pkg::hvd_cfg_t             cfg
);
    import hvd_pkg::*;

    hvd_cfg_t             cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_voltage <= TARGET_W'(TARGET_RESET);
            cfg_reg.prop_gain      <= GAIN_W'(PROP_RESET);
            cfg_reg.integ_gain     <= GAIN_W'(INTEG_RESET);
            cfg_reg.deriv_gain     <= GAIN_W'(DERIV_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TARGET: cfg_reg.target_voltage <= pwdata[TARGET_W-1:0];
                REG_PROP:   cfg_reg.prop_gain      <= pwdata[GAIN_W-1:0];
                REG_INTEG:  cfg_reg.integ_gain     <= pwdata[GAIN_W-1:0];
                REG_DERIV:  cfg_reg.deriv_gain     <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Gains read back sign-extended to the bus width.
    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET: prdata = APB_DATA_W'(cfg_reg.target_voltage);
            REG_PROP:   prdata = APB_DATA_W'($signed(cfg_reg.prop_gain));
            REG_INTEG:  prdata = APB_DATA_W'($signed(cfg_reg.integ_gain));
            REG_DERIV:  prdata = APB_DATA_W'($signed(cfg_reg.deriv_gain));
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: rtl/hvd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hvd_pkg for the operand widths and hvd_mul_req_t.
module hvd_mul (
    input  logic                             clk,
    input  hvd_pkg::hvd_mul_req_t            req,
    output logic signed [hvd_pkg::PROD_W-1:0] prod
);
    import hvd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(req.a) * $signed(req.b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/hvd_core.sv
// Sequencer and datapath of the voltage loop: rail conversion, PID terms,
// duty clamp and the output register. Drives the shared multiplier.
// Depends on hvd_pkg, hvd_if.sv and hv_divider_pid_duty_macros.svh.
`include "hv_divider_pid_duty_macros.svh"

module hvd_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hvd_pkg::hvd_cfg_t                cfg,
    hvd_sample_if.sink                       sample,
    hvd_result_if.source                     result,
    output hvd_pkg::hvd_mul_req_t            mul_req,
    input  logic signed [hvd_pkg::PROD_W-1:0] mul_prod
);
    import hvd_pkg::*;

    localparam logic signed [INTEGRAL_BITS-1:0] IMAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] IMIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

    hvd_state_t state_reg;
    hvd_state_t state_next;

    logic [MV_W-1:0]                 mv_reg;
    logic [N_W-1:0]                  n_reg;
    logic signed [RAIL_W-1:0]        rail_reg;
    logic signed [ERR_W-1:0]         err_reg;
    logic signed [DERR_W-1:0]        derr_reg;
    logic signed [ERR50_W-1:0]       err50_reg;
    logic signed [DERR2500_W-1:0]    d2500_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic                            duty_zero_reg;
    logic                            duty_max_reg;
    logic signed [INTEGRAL_BITS-1:0] isum_reg;
    logic signed [ERR_W-1:0]         last_err_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [DUTY_BITS-1:0]            duty_out_reg;
    logic signed [RAIL_W-1:0]        rail_out_reg;

    logic [QRAIL_W-1:0]              q_rail;
    logic signed [ERR_W-1:0]         rail_wide;
    logic signed [RAIL_W-1:0]        rail_sat;
    logic signed [ERR_W-1:0]         err_calc;
    logic signed [ISUM_W-1:0]        isum_wide;
    logic signed [INTEGRAL_BITS-1:0] isum_next;
    logic signed [ERR50_W-1:0]       err_ext50;
    logic signed [ERR50_W-1:0]       err50_calc;
    logic signed [DERR2500_W-1:0]    derr_ext;
    logic signed [DERR2500_W-1:0]    d2500_calc;
    logic signed [H_W-1:0]           h_val;
    logic                            h_neg;
    logic                            h_big;
    logic [DUTY_BITS-1:0]            quot;
    logic [DUTY_BITS-1:0]            duty_next;
    logic                            load;

    assign sample.ready = (state_reg == ST_IDLE);
    assign load         = (state_reg == ST_QUO) && (!out_valid_reg || result.ready);

    assign result.valid        = out_valid_reg;
    assign result.pwm_duty     = duty_out_reg;
    assign result.rail_voltage = rail_out_reg;

    // Rail conversion from the reciprocal product.
    assign q_rail    = mul_prod[RAIL_SHIFT +: QRAIL_W];
    assign rail_wide = $signed({1'b0, q_rail}) - ERR_W'(OFFSET_Q8);
    assign rail_sat  = (rail_wide > ERR_W'(RAIL_MAX)) ? RAIL_W'(RAIL_MAX)
                                                      : rail_wide[RAIL_W-1:0];
    assign err_calc  = $signed({2'b00, cfg.target_voltage}) - ERR_W'(rail_reg);

    // Integral with saturation at its signed bounds.
    assign isum_wide = ISUM_W'(isum_reg) + ISUM_W'(err_reg);
    always_comb
    begin
        if (isum_wide[ISUM_W-1] != isum_wide[ISUM_W-2])
        begin
            isum_next = isum_wide[ISUM_W-1] ? IMIN : IMAX;
        end
        else
        begin
            isum_next = isum_wide[INTEGRAL_BITS-1:0];
        end
    end

    // Step-rate factors by shift and add: 50 = 32+16+2, 2500 = 2048+256+128+64+4.
    assign err_ext50  = ERR50_W'(err_reg);
    assign err50_calc = (err_ext50 <<< 5) + (err_ext50 <<< 4) + (err_ext50 <<< 1);
    assign derr_ext   = DERR2500_W'(derr_reg);
    assign d2500_calc = (derr_ext <<< 11) + (derr_ext <<< 8) + (derr_ext <<< 7)
                      + (derr_ext <<< 6) + (derr_ext <<< 2);

    // Whole duty counts times the step rate, floored.
    assign h_val = acc_reg[ACC_W-1:ILO_W];
    assign h_neg = h_val[H_W-1];
    assign h_big = !h_neg && (h_val >= H_W'(H_LIMIT));
    assign quot  = mul_prod[QUO_SHIFT +: DUTY_BITS];

    always_comb
    begin
        if (duty_zero_reg)
        begin
            duty_next = '0;
        end
        else if (duty_max_reg)
        begin
            duty_next = DUTY_BITS'(DUTY_LIMIT);
        end
        else
        begin
            duty_next = quot;
        end
    end

    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            ST_SCALE:
            begin
                mul_req.a = MUL_W'(mv_reg);
                mul_req.b = MUL_W'(SCALE_MUL);
            end
            ST_DIVR:
            begin
                mul_req.a = MUL_W'(n_reg);
                mul_req.b = MUL_W'(RAIL_RECIP);
            end
            ST_MP:
            begin
                mul_req.a = MUL_W'($signed(cfg.prop_gain));
                mul_req.b = MUL_W'(err50_reg);
            end
            ST_MD:
            begin
                mul_req.a = MUL_W'($signed(cfg.deriv_gain));
                mul_req.b = MUL_W'(d2500_reg);
            end
            ST_MIL:
            begin
                mul_req.a = MUL_W'($signed(cfg.integ_gain));
                mul_req.b = MUL_W'(isum_reg[ILO_W-1:0]);
            end
            ST_MIH:
            begin
                mul_req.a = MUL_W'($signed(cfg.integ_gain));
                mul_req.b = MUL_W'(isum_reg >>> ILO_W);
            end
            // The quotient is reissued while the output register is full.
            ST_CLAMP, ST_QUO:
            begin
                mul_req.a = MUL_W'(h_val[HQ_W-1:0]);
                mul_req.b = MUL_W'(QUO_RECIP);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample.valid) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OFFS;
            ST_OFFS:  state_next = ST_DIVR;
            ST_DIVR:  state_next = ST_RAIL;
            ST_RAIL:  state_next = ST_ERR;
            ST_ERR:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_MP;
            ST_MP:    state_next = ST_MD;
            ST_MD:    state_next = ST_MIL;
            ST_MIL:   state_next = ST_MIH;
            ST_MIH:   state_next = ST_SUMH;
            ST_SUMH:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_QUO;
            ST_QUO:   if (load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            isum_reg      <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_UPD)
            begin
                isum_reg     <= isum_next;
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:  if (sample.valid) mv_reg <= sample.sense_millivolts;
            ST_OFFS:  n_reg <= mul_prod[N_W-1:0] + N_W'(RAIL_ROUND);
            ST_RAIL:  rail_reg <= rail_sat;
            ST_ERR:   err_reg <= err_calc;
            ST_UPD:
            begin
                derr_reg  <= DERR_W'(err_reg) - DERR_W'(last_err_reg);
                err50_reg <= err50_calc;
            end
            ST_MP:    d2500_reg <= d2500_calc;
            ST_MD:    acc_reg <= ACC_W'(mul_prod);
            ST_MIL:   acc_reg <= acc_reg + ACC_W'(mul_prod);
            ST_MIH:   acc_reg <= acc_reg + ACC_W'(mul_prod);
            ST_SUMH:  acc_reg <= acc_reg + (ACC_W'(mul_prod) <<< ILO_W);
            ST_CLAMP:
            begin
                duty_zero_reg <= h_neg;
                duty_max_reg  <= h_big;
            end
            default:  ;
        endcase
        if (load)
        begin
            duty_out_reg <= duty_next;
            rail_out_reg <= rail_reg;
        end
    end

    `HVD_ASSERT_SAME(a_duty_range, result.valid, result.pwm_duty <= DUTY_BITS'(DUTY_LIMIT), "duty above limit")
    `HVD_ASSERT_SAME(a_rail_range, result.valid, (result.rail_voltage <= RAIL_W'(RAIL_MAX)) && (result.rail_voltage >= -RAIL_W'(OFFSET_Q8)), "rail out of range")
    `HVD_ASSERT_SAME(a_load_src, $rose(out_valid_reg), $past(state_reg) == ST_QUO, "result loaded outside final step")
    `HVD_ASSERT_NEXT(a_stall_hold, (state_reg == ST_QUO) && out_valid_reg && !result.ready, state_reg == ST_QUO, "final step left while output full")

endmodule

FILE: rtl/hv_divider_pid_duty.sv
// Top level of the high-voltage divider PID loop with clamped PWM duty.
// Depends on hvd_pkg, hvd_if.sv, hvd_regs, hvd_mul and hvd_core.
//
// Channel  Dir  Handshake            Payload
// sample   in   valid / ready        sense_millivolts[11:0]
// result   out  valid / ready        pwm_duty[9:0], rail_voltage[17:0] signed
// apb      in   psel/penable/pready  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// The sequencer steps one shared 33x33 multiplier through its thirteen working
// states for each request and takes no new request until the last one is done.
// The input is ready only while the sequencer is idle. A finished result
// waits in the output register, so the next request is accepted meanwhile;
// if that register is still full when a new result is ready, the last step holds.
// Reset clears the integral and the previous error and restores register defaults.
module hv_divider_pid_duty (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hvd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hvd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hvd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    hvd_sample_if.sink                     sample,
    hvd_result_if.source                   result
);
    import hvd_pkg::*;

    hvd_cfg_t                 cfg;
    hvd_mul_req_t             mul_req;
    logic signed [PROD_W-1:0] mul_prod;

    hvd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hvd_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    hvd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .sample   (sample),
        .result   (result),
        .mul_req  (mul_req),
        .mul_prod (mul_prod)
    );

endmodule

FILE: tb/tb_hv_divider_pid_duty.sv
`timescale 1ns / 1ps
// Self-checking testbench for hv_divider_pid_duty: a directed script, partly pinned, then
// random phases under several register settings; the rest checked against a loop model.
// Depends on hvd_pkg, the channel interfaces in hvd_if.sv and the block's RTL.
module tb_hv_divider_pid_duty;
    import hvd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int IDLE_PERCENT     = 6;
    localparam int SEND_GAP_PERCENT = 10;
    localparam int HOLD_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int N_PHASES         = 8;
    localparam int PHASE_ITEMS      = 55;
    localparam int REPORT_LIMIT     = 10;
    localparam int TARGET_TOP       = 131071;

    localparam longint SCALE_NUM   = 80544;
    localparam longint SCALE_DEN   = 2125;
    localparam longint SCALE_HALF  = 1062;
    localparam longint RAIL_OFFSET = 10240;
    localparam longint RAIL_TOP    = 131071;
    localparam longint ISUM_MAX    = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 1;
    localparam longint ISUM_MIN    = -ISUM_MAX - 1;
    localparam longint RATE        = 50;

    typedef struct packed {
        logic [DUTY_BITS-1:0]     duty;
        logic signed [RAIL_W-1:0] rail;
    } loop_out_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_READING,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [REG_IDX_W-1:0]     idx;
        logic [APB_DATA_W-1:0]    value;
        logic [MV_W-1:0]          mv;
        logic [DUTY_BITS-1:0]     duty;
        logic signed [RAIL_W-1:0] rail;
    } script_row_t;

    localparam int N_DIRECTED = 25;
    localparam script_row_t DIRECTED [N_DIRECTED] = '{
        // The first reading takes its derivative against a zero previous error.
        '{ROW_READING, REG_TARGET, 32'd0,          12'd0,    10'd0,   18'sd0},
        '{ROW_CHECKED, REG_TARGET, 32'd0,          12'd4095, 10'd0,   18'sd131071},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd3300, 10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd3301, 10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd3728, 10'd0,   18'sd0},
        '{ROW_CHECKED, REG_TARGET, 32'd0,          12'd3729, 10'd0,   18'sd131071},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd1,    10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd270,  10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd2048, 10'd0,   18'sd0},
        '{ROW_WRITE,   REG_TARGET, 32'h0001_FFFF,  12'd0,    10'd0,   18'sd0},
        '{ROW_WRITE,   REG_PROP,   32'h007F_FFFF,  12'd0,    10'd0,   18'sd0},
        '{ROW_CHECKED, REG_TARGET, 32'd0,          12'd0,    10'd818, -18'sd10240},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd4095, 10'd0,   18'sd0},
        '{ROW_WRITE,   REG_PROP,   32'hFF80_0000,  12'd0,    10'd0,   18'sd0},
        '{ROW_CHECKED, REG_TARGET, 32'd0,          12'd0,    10'd0,   -18'sd10240},
        '{ROW_WRITE,   REG_INTEG,  32'h007F_FFFF,  12'd0,    10'd0,   18'sd0},
        '{ROW_WRITE,   REG_DERIV,  32'hFF80_0000,  12'd0,    10'd0,   18'sd0},
        '{ROW_WRITE,   REG_PROP,   32'd0,          12'd0,    10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd1000, 10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd3500, 10'd0,   18'sd0},
        '{ROW_WRITE,   REG_INTEG,  32'hFF80_0000,  12'd0,    10'd0,   18'sd0},
        '{ROW_WRITE,   REG_DERIV,  32'h007F_FFFF,  12'd0,    10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd0,    10'd0,   18'sd0},
        '{ROW_READING, REG_TARGET, 32'd0,          12'd4095, 10'd0,   18'sd0},
        '{ROW_WRITE,   REG_TARGET, 32'd0,          12'd0,    10'd0,   18'sd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hvd_sample_if reading_ch ();
    hvd_result_if duty_ch ();

    hv_divider_pid_duty uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (reading_ch),
        .result  (duty_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Register copies as the block should hold them, and the loop state.
    logic [APB_DATA_W-1:0] reg_shadow [4];
    longint                err_total;
    longint                err_prev;

    loop_out_t duty_due [$];
    int        fault_count = 0;
    bit        calm;
    int        hold_asks;

    function automatic void flag_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
        return (idx == REG_TARGET) ? APB_DATA_W'((1 << TARGET_W) - 1)
                                   : APB_DATA_W'((1 << GAIN_W) - 1);
    endfunction

    // One control step: rail conversion, integral and derivative update, duty clamp.
    function automatic loop_out_t advance_loop(input logic [MV_W-1:0] mv);
        longint                   rail;
        longint                   err;
        longint                   derr;
        longint                   isum;
        logic signed [95:0]       total;
        logic signed [95:0]       whole;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        loop_out_t                o;
        kp = reg_shadow[REG_PROP][GAIN_W-1:0];
        ki = reg_shadow[REG_INTEG][GAIN_W-1:0];
        kd = reg_shadow[REG_DERIV][GAIN_W-1:0];
        rail = (longint'(mv) * SCALE_NUM + SCALE_HALF) / SCALE_DEN - RAIL_OFFSET;
        if (rail > RAIL_TOP)
            rail = RAIL_TOP;
        err = longint'(reg_shadow[REG_TARGET][TARGET_W-1:0]) - rail;
        isum = err_total + err;
        if (isum > ISUM_MAX)
            isum = ISUM_MAX;
        else if (isum < ISUM_MIN)
            isum = ISUM_MIN;
        err_total = isum;
        derr = err - err_prev;
        err_prev = err;
        // Sum in 2^-24 duty counts times the step rate; the wide width keeps it exact.
        total = ki * isum + RATE * kp * err + RATE * RATE * kd * derr;
        whole = total >>> 24;
        if (whole < 0)
            o.duty = '0;
        else if (whole / RATE > DUTY_LIMIT)
            o.duty = DUTY_BITS'(DUTY_LIMIT);
        else
            o.duty = DUTY_BITS'(whole / RATE);
        o.rail = RAIL_W'(rail);
        return o;
    endfunction

    // Most readings sit near the setpoint so that the duty lands inside its range.
    function automatic logic [MV_W-1:0] pick_reading(input int set_q8);
        int          centre;
        int          jitter;
        int unsigned roll;
        logic [MV_W-1:0] mv;
        roll = $urandom_range(99);
        jitter = int'($urandom_range(120)) - 60;
        centre = (set_q8 + 10240) * 2125 / 80544 + jitter;
        if (roll < 70)
            mv = (centre < 0) ? '0 : MV_W'(centre);
        else if (roll < 90)
            mv = MV_W'($urandom_range(4095));
        else
        begin
            case ($urandom_range(2))
                0:       mv = '0;
                1:       mv = 12'd3300;
                default: mv = 12'd4095;
            endcase
        end
        return mv;
    endfunction

    task automatic apb_access(input logic is_write, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, idx, '0, got);
        if ((got & reg_mask(idx)) !== reg_shadow[idx])
            flag_fault($sformatf("register %0d reads %h, expected %h",
                                 idx, got & reg_mask(idx), reg_shadow[idx]));
    endtask

    task automatic program_register(input logic [REG_IDX_W-1:0] idx,
                                    input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        reg_shadow[idx] = value & reg_mask(idx);
        check_register(idx);
    endtask

    // Stop offering readings and wait for every outstanding result.
    task automatic settle_loop();
        reading_ch.valid <= 1'b0;
        while (duty_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_reading(input logic [MV_W-1:0] mv, input bit pinned,
                                input loop_out_t pinned_out);
        loop_out_t want;
        if (!calm && $urandom_range(99) < SEND_GAP_PERCENT)
        begin
            reading_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        reading_ch.valid            <= 1'b1;
        reading_ch.sense_millivolts <= mv;
        do
            @(posedge clk);
        while (!reading_ch.ready);
        want = advance_loop(mv);
        duty_due.push_back(pinned ? pinned_out : want);
    endtask

    initial
    begin : stimulus
        loop_out_t             pinned;
        script_row_t           row;
        int                    set_q8;
        logic [APB_DATA_W-1:0] kp;
        logic [APB_DATA_W-1:0] ki;
        logic [APB_DATA_W-1:0] kd;
        reading_ch.valid            <= 1'b0;
        reading_ch.sense_millivolts <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        rst_n     <= 1'b0;
        calm      <= 1'b0;
        hold_asks <= 0;
        err_total = 0;
        err_prev  = 0;
        reg_shadow[REG_TARGET] = APB_DATA_W'(TARGET_RESET);
        reg_shadow[REG_PROP]   = APB_DATA_W'(PROP_RESET);
        reg_shadow[REG_INTEG]  = APB_DATA_W'(INTEG_RESET);
        reg_shadow[REG_DERIV]  = APB_DATA_W'(DERIV_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        check_register(REG_TARGET);
        check_register(REG_PROP);
        check_register(REG_INTEG);
        check_register(REG_DERIV);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_WRITE:
                begin
                    settle_loop();
                    program_register(row.idx, row.value);
                end
                ROW_READING:
                    send_reading(row.mv, 1'b0, '0);
                default:
                begin
                    pinned.duty = row.duty;
                    pinned.rail = row.rail;
                    send_reading(row.mv, 1'b1, pinned);
                end
            endcase
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_q8 = $urandom_range(TARGET_TOP);
            kp = 32'($urandom_range(100000)) - 32'd20000;
            ki = 32'($urandom_range(10000)) - 32'd2000;
            kd = 32'($urandom_range(10000)) - 32'd2000;
            case (p)
                0:
                begin
                    kp = APB_DATA_W'(PROP_RESET);
                    ki = APB_DATA_W'(INTEG_RESET);
                    kd = APB_DATA_W'(DERIV_RESET);
                end
                1: set_q8 = TARGET_TOP;
                2:
                begin
                    set_q8 = 0;
                    kp = 32'h007F_FFFF;
                    ki = 32'h007F_FFFF;
                    kd = 32'h007F_FFFF;
                end
                3:
                begin
                    kp = 32'hFF80_0000;
                    ki = 32'hFF80_0000;
                    kd = 32'hFF80_0000;
                end
                4:
                begin
                    kp = '0;
                    ki = '0;
                    kd = '0;
                end
                7:
                begin
                    // Upper bits carry noise; only the low 24 bits are kept.
                    kp = $urandom();
                    ki = $urandom();
                    kd = $urandom();
                end
                default: ;
            endcase
            settle_loop();
            program_register(REG_TARGET, APB_DATA_W'(set_q8));
            program_register(REG_PROP, kp);
            program_register(REG_INTEG, ki);
            program_register(REG_DERIV, kd);
            calm <= (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // The sink holds off while requests keep coming, so the block backs up.
                if (p == 1 && i == 10)
                    hold_asks <= hold_asks + 1;
                send_reading(pick_reading(set_q8), 1'b0, '0);
            end
        end

        settle_loop();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : duty_sink
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        duty_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_asks)
            begin
                holds_seen = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                duty_ch.ready <= 1'b0;
            end
            else
                duty_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin : result_check
        loop_out_t want;
        if (rst_n && duty_ch.valid && duty_ch.ready)
        begin
            if (duty_due.size() == 0)
                flag_fault($sformatf("result with no request pending: duty %0d rail %0d",
                                     duty_ch.pwm_duty, duty_ch.rail_voltage));
            else
            begin
                want = duty_due.pop_front();
                if (duty_ch.pwm_duty !== want.duty)
                    flag_fault($sformatf("pwm_duty %0d, expected %0d",
                                         duty_ch.pwm_duty, want.duty));
                if (duty_ch.rail_voltage !== want.rail)
                    flag_fault($sformatf("rail_voltage %0d, expected %0d",
                                         duty_ch.rail_voltage, want.rail));
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((reading_ch.valid && reading_ch.ready) || (duty_ch.valid && duty_ch.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_if.sv
rtl/hvd_regs.sv
rtl/hvd_mul.sv
rtl/hvd_core.sv
rtl/hv_divider_pid_duty.sv
tb/tb_hv_divider_pid_duty.sv
